// ===== hdl/lpsfr_pkg.sv =====
// shared types and constants for the length prefixed slot frame receiver
// no dependencies; used by every module of the block

package lpsfr_pkg;

    localparam int SLOTS_DEF         = 16;
    localparam int PAYLOAD_BYTES_DEF = 16;
    localparam int SIZE_OVERHEAD     = 2;   // type and slot bytes counted in the size
    localparam int BYTE_W            = 8;
    localparam int COUNT_W           = 32;

    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] fetch_slot;
    } t_in_item;

    typedef struct packed {
        logic               frame_done;
        logic               frame_stored;
        logic [BYTE_W-1:0]  frame_slot;
        logic [COUNT_W-1:0] total_frames;
        logic [COUNT_W-1:0] stored_frames;
        logic [BYTE_W-1:0]  fetch_byte;
        logic               fetch_pending;
        logic               last_of_run;
    } t_out_item;

    // outcome of one parsed byte, handed from parser to output sequencer
    typedef struct packed {
        logic               done;
        logic               stored;
        logic [BYTE_W-1:0]  slot;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] nstored;
    } t_frame_evt;

endpackage

// ===== hdl/lpsfr_parser.sv =====
// byte stream parser: size check, frame staging, type/slot/length check, counters
// depends on lpsfr_pkg

module lpsfr_parser #(
    parameter int SLOTS         = lpsfr_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BYTES = lpsfr_pkg::PAYLOAD_BYTES_DEF,
    parameter int SLOT_W        = 4,
    parameter int ROW_W         = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [lpsfr_pkg::BYTE_W-1:0]      i_byte,
    input  logic [lpsfr_pkg::BYTE_W-1:0]      i_type_code,
    output lpsfr_pkg::t_frame_evt             o_evt,
    output logic                              o_wr_en,
    output logic [SLOT_W-1:0]                 o_wr_slot,
    output logic [ROW_W-1:0]                  o_wr_row
);
    import lpsfr_pkg::*;

    localparam int FRAME_MAX = SIZE_OVERHEAD + PAYLOAD_BYTES;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);
    localparam int BUF_IW    = $clog2(FRAME_MAX);

    typedef enum logic [1:0] {
        PH_SIZE_LO,
        PH_SIZE_HI,
        PH_BODY
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_size_lo, n_size_lo;
    logic [CNT_W-1:0]    r_len, n_len;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [COUNT_W-1:0]  r_total, n_total;
    logic [COUNT_W-1:0]  r_stored, n_stored;
    logic [BYTE_W-1:0]   r_buf [FRAME_MAX];

    logic                done;
    logic                store_ok;
    logic [BYTE_W-1:0]   cur_type;
    logic [BYTE_W-1:0]   cur_slot;

    always_comb begin
        n_phase   = r_phase;
        n_size_lo = r_size_lo;
        n_len     = r_len;
        n_cnt     = r_cnt;
        done      = 1'b0;
        case (r_phase)
            PH_SIZE_HI: begin
                if (i_byte == '0 && r_size_lo >= BYTE_W'(SIZE_OVERHEAD)
                        && r_size_lo <= BYTE_W'(FRAME_MAX)) begin
                    n_len   = CNT_W'(r_size_lo);
                    n_cnt   = '0;
                    n_phase = PH_BODY;
                end else begin
                    n_phase = PH_SIZE_LO;
                end
            end
            PH_BODY: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (n_cnt >= r_len) begin
                    done    = 1'b1;
                    n_phase = PH_SIZE_LO;
                end
            end
            default: begin
                n_size_lo = i_byte;
                n_phase   = PH_SIZE_HI;
            end
        endcase
    end

    // type and slot may be the byte arriving now on a short frame
    assign cur_type = (r_cnt == CNT_W'(0)) ? i_byte : r_buf[0];
    assign cur_slot = (r_cnt == CNT_W'(1)) ? i_byte : r_buf[1];

    assign store_ok = done && (cur_type == i_type_code)
                      && ({1'b0, cur_slot} < (BYTE_W + 1)'(SLOTS))
                      && (r_len == CNT_W'(FRAME_MAX));

    assign n_total  = done     ? r_total + COUNT_W'(1)  : r_total;
    assign n_stored = store_ok ? r_stored + COUNT_W'(1) : r_stored;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIZE_LO;
            r_size_lo <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_total   <= '0;
            r_stored  <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_size_lo <= n_size_lo;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_total   <= n_total;
            r_stored  <= n_stored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && r_phase == PH_BODY && r_cnt < CNT_W'(FRAME_MAX)) begin
            r_buf[r_cnt[BUF_IW-1:0]] <= i_byte;
        end
    end

    // payload row, last byte taken straight from the stream
    always_comb begin
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            if (k == PAYLOAD_BYTES - 1) begin
                o_wr_row[k*BYTE_W +: BYTE_W] = i_byte;
            end else begin
                o_wr_row[k*BYTE_W +: BYTE_W] = r_buf[k + SIZE_OVERHEAD];
            end
        end
    end

    assign o_wr_en   = i_step && store_ok;
    assign o_wr_slot = cur_slot[SLOT_W-1:0];

    assign o_evt.done    = done;
    assign o_evt.stored  = store_ok;
    assign o_evt.slot    = done ? cur_slot : '0;
    assign o_evt.total   = n_total;
    assign o_evt.nstored = n_stored;

endmodule

// ===== hdl/lpsfr_slot_store.sv =====
// slot payload memory, one row per slot, with per-slot pending flags
// depends on lpsfr_pkg

module lpsfr_slot_store #(
    parameter int SLOTS  = lpsfr_pkg::SLOTS_DEF,
    parameter int SLOT_W = 4,
    parameter int ROW_W  = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [SLOT_W-1:0]             i_wr_slot,
    input  logic [ROW_W-1:0]              i_wr_row,
    input  logic                          i_rd_en,
    input  logic [lpsfr_pkg::BYTE_W-1:0]  i_rd_slot,
    output logic [ROW_W-1:0]              o_rd_row,
    output logic                          o_rd_pend
);
    import lpsfr_pkg::*;

    logic [ROW_W-1:0] r_mem [SLOTS];
    logic [ROW_W-1:0] r_rd_row;
    logic [SLOTS-1:0] r_pend;
    logic             r_rd_pend;
    logic             rd_in_range;
    logic [SLOT_W-1:0] rd_idx;

    assign rd_in_range = {1'b0, i_rd_slot} < (BYTE_W + 1)'(SLOTS);
    assign rd_idx      = i_rd_slot[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_pend[i_wr_slot] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_pend <= rd_in_range && r_pend[rd_idx];
                if (rd_in_range) begin
                    r_pend[rd_idx] <= 1'b0;
                end
            end
        end
    end

    assign o_rd_row  = r_rd_row;
    assign o_rd_pend = r_rd_pend;

endmodule

// ===== hdl/lpsfr_out_seq.sv =====
// result register and fetch serializer: one result per feed, a byte run per fetch
// depends on lpsfr_pkg

module lpsfr_out_seq #(
    parameter int PAYLOAD_BYTES = lpsfr_pkg::PAYLOAD_BYTES_DEF,
    parameter int ROW_W         = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_is_fetch,
    input  lpsfr_pkg::t_frame_evt  i_evt,
    input  logic [ROW_W-1:0]       i_rd_row,
    input  logic                   i_rd_pend,
    input  logic                   i_ready,
    output logic                   o_valid,
    output lpsfr_pkg::t_out_item   o_item,
    output logic                   o_last_take
);
    import lpsfr_pkg::*;

    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic              r_valid;
    logic              r_fetch;
    t_frame_evt        r_evt;
    logic [IDX_W-1:0]  r_idx;
    logic              last;
    logic [BYTE_W-1:0] cur_byte;

    assign last     = !r_fetch || (r_idx == IDX_W'(PAYLOAD_BYTES - 1));
    assign cur_byte = i_rd_row[r_idx*BYTE_W +: BYTE_W];

    assign o_last_take = r_valid && i_ready && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fetch <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_fetch <= i_is_fetch;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_evt <= i_evt;
        end
    end

    always_comb begin
        o_item = '0;
        if (r_fetch) begin
            o_item.fetch_byte    = i_rd_pend ? cur_byte : '0;
            o_item.fetch_pending = i_rd_pend;
        end else begin
            o_item.frame_done    = r_evt.done;
            o_item.frame_stored  = r_evt.stored;
            o_item.frame_slot    = r_evt.slot;
            o_item.total_frames  = r_evt.total;
            o_item.stored_frames = r_evt.nstored;
        end
        o_item.last_of_run = last;
    end

    assign o_valid = r_valid;

endmodule

// ===== hdl/length_prefixed_slot_frame_receiver.sv =====
// path: a transfer passes the input register, then the result register once that is free
// occupancy: a feed byte gives one result; a fetch holds the result side for one output
//   transfer per payload byte read from the registered slot row
// reset: synchronous active low; clears parser, counters, pending flags and the
//   type code; slot memory and frame staging keep no reset and need no clearing pass

module length_prefixed_slot_frame_receiver #(
    parameter int SLOTS         = lpsfr_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BYTES = lpsfr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lpsfr_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lpsfr_pkg::t_out_item          o_out_item,
    input  logic                          i_cfg_we,
    input  logic [lpsfr_pkg::BYTE_W-1:0]  i_cfg_data
);
    import lpsfr_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W  = PAYLOAD_BYTES * BYTE_W;

    // input register, parts the host side from the result side
    logic              r_in_valid;
    t_in_item          r_in;
    logic [BYTE_W-1:0] r_type_code;

    logic              move;
    logic              last_take;
    logic              feed_step;
    logic              fetch_step;
    t_frame_evt        evt;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [ROW_W-1:0]  wr_row;
    logic [ROW_W-1:0]  rd_row;
    logic              rd_pend;

    // held item goes into the result register once that is free or finishing
    assign move       = r_in_valid && (!o_out_valid || last_take);
    assign o_in_ready = !r_in_valid || move;
    assign feed_step  = move && (r_in.opcode == OP_FEED);
    assign fetch_step = move && (r_in.opcode == OP_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_type_code <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_type_code <= i_cfg_data;
            end
        end
    end

    // payload of the input register, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
    end

    // parser sees a byte exactly when a feed transfer moves out
    lpsfr_parser #(
        .SLOTS         (SLOTS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .SLOT_W        (SLOT_W),
        .ROW_W         (ROW_W)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (feed_step),
        .i_byte      (r_in.data_byte),
        .i_type_code (r_type_code),
        .o_evt       (evt),
        .o_wr_en     (wr_en),
        .o_wr_slot   (wr_slot),
        .o_wr_row    (wr_row)
    );

    // one row write per stored frame, one row read per fetch; never both at once
    lpsfr_slot_store #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W),
        .ROW_W  (ROW_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_slot (wr_slot),
        .i_wr_row  (wr_row),
        .i_rd_en   (fetch_step),
        .i_rd_slot (r_in.fetch_slot),
        .o_rd_row  (rd_row),
        .o_rd_pend (rd_pend)
    );

    // result register; fetch runs step through the row a byte per transfer
    lpsfr_out_seq #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .ROW_W         (ROW_W)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (move),
        .i_is_fetch  (r_in.opcode == OP_FETCH),
        .i_evt       (evt),
        .i_rd_row    (rd_row),
        .i_rd_pend   (rd_pend),
        .i_ready     (i_out_ready),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item),
        .o_last_take (last_take)
    );

    // a stored frame is always a completed one
    a_stored_implies_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.frame_stored |-> o_out_item.frame_done)
        else $error("frame_stored without frame_done");

    // a fetch run keeps going until its last byte
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last_of_run |=> o_out_valid)
        else $error("fetch run ended early");

    // a held item moves into a free result register
    a_held_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_out_valid |=> o_out_valid)
        else $error("held item did not move to result register");

endmodule
